### hw/rtl/lfl_pkg.sv
// lfl_pkg: shared types and codes for the linked free list with stall count
// no dependencies

package lfl_pkg;

  localparam int OP_BITS = 3;

  localparam logic [2:0] FUNC_PUSH         = 3'd0;
  localparam logic [2:0] FUNC_POP          = 3'd1;
  localparam logic [2:0] FUNC_POP_STALL    = 3'd2;
  localparam logic [2:0] FUNC_PUSH_UNSTALL = 3'd3;
  localparam logic [2:0] FUNC_PUSH_HANDOFF = 3'd4;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_NULL     = 2'd2;

  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH         = 3'd0,
    OP_POP          = 3'd1,
    OP_POP_STALL    = 3'd2,
    OP_PUSH_UNSTALL = 3'd3,
    OP_PUSH_HANDOFF = 3'd4,
    OP_NULL_PUSH    = 3'd5,
    OP_NOP          = 3'd6
  } op_code_t;

  typedef enum logic [1:0] {
    S_RUN      = 2'b01,
    S_POP_WAIT = 2'b10
  } back_state_t;

endpackage

### hw/rtl/lfl_front.sv
// lfl_front: accepts input transactions and classifies them into list operations
// depends on lfl_pkg; feeds lfl_queue

module lfl_front #(
  parameter int BATCH_BITS = 4,
  parameter int INDEX_BITS = 6
) (
  input  logic                                        item_valid,
  output logic                                        item_stall,
  input  logic [2:0]                                  func,
  input  logic [BATCH_BITS+INDEX_BITS-1:0]            entry_link,
  input  logic                                        q_full,
  output logic                                        q_wr,
  output logic [lfl_pkg::OP_BITS+BATCH_BITS+INDEX_BITS-1:0] q_wr_data
);

  localparam int LINK_BITS = BATCH_BITS + INDEX_BITS;

  logic             is_null;
  lfl_pkg::op_code_t code;

  assign is_null = (entry_link[LINK_BITS-1 -: BATCH_BITS] == {BATCH_BITS{1'b1}});

  always_comb begin
    unique case (func)
      lfl_pkg::FUNC_PUSH:         code = is_null ? lfl_pkg::OP_NULL_PUSH : lfl_pkg::OP_PUSH;
      lfl_pkg::FUNC_POP:          code = lfl_pkg::OP_POP;
      lfl_pkg::FUNC_POP_STALL:    code = lfl_pkg::OP_POP_STALL;
      lfl_pkg::FUNC_PUSH_UNSTALL: code = is_null ? lfl_pkg::OP_NULL_PUSH
                                                 : lfl_pkg::OP_PUSH_UNSTALL;
      lfl_pkg::FUNC_PUSH_HANDOFF: code = is_null ? lfl_pkg::OP_NULL_PUSH
                                                 : lfl_pkg::OP_PUSH_HANDOFF;
      default:                    code = lfl_pkg::OP_NOP;
    endcase
  end

  assign item_stall = q_full;
  assign q_wr       = item_valid && !q_full;
  assign q_wr_data  = {code, entry_link};

endmodule

### hw/rtl/lfl_queue.sv
// lfl_queue: two-entry queue of classified operations between front and back
// no package dependencies

module lfl_queue #(
  parameter int WIDTH = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  output logic             rd_valid,
  input  logic             rd_stall,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             rd;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd       = rd_valid && !rd_stall;
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/lfl_back.sv
// lfl_back: carries out list operations on head link, stall count and next-link memory
// depends on lfl_pkg; fed by lfl_queue, drives the result channel

module lfl_back #(
  parameter int BATCH_BITS = 4,
  parameter int INDEX_BITS = 6,
  parameter int STALL_BITS = 4
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        q_valid,
  output logic                                        q_stall,
  input  logic [lfl_pkg::OP_BITS+BATCH_BITS+INDEX_BITS-1:0] q_data,
  output logic                                        result_valid,
  input  logic                                        result_stall,
  output logic [BATCH_BITS+INDEX_BITS-1:0]            popped_link,
  output logic                                        got_entry,
  output logic                                        unstalled,
  output logic [1:0]                                  status,
  output logic [STALL_BITS-1:0]                       waiters
);

  localparam int LINK_BITS = BATCH_BITS + INDEX_BITS;
  localparam longint unsigned DEPTH = 64'd1 << LINK_BITS;
  localparam logic [LINK_BITS-1:0] NULL_LINK = {{BATCH_BITS{1'b1}}, {INDEX_BITS{1'b0}}};

  logic [LINK_BITS-1:0]  mem [DEPTH];
  logic [LINK_BITS-1:0]  rdata;

  lfl_pkg::back_state_t  state, state_next;
  logic [LINK_BITS-1:0]  head_link, head_link_next;
  logic [STALL_BITS-1:0] stall_count, stall_count_next;

  lfl_pkg::op_code_t     code;
  logic [LINK_BITS-1:0]  link;
  logic                  take;
  logic                  head_null;
  logic                  do_push;
  logic                  res_got;
  logic                  res_unst;
  logic [1:0]            res_status;
  logic [LINK_BITS-1:0]  res_popped;

  assign code      = lfl_pkg::op_code_t'(q_data[lfl_pkg::OP_BITS+LINK_BITS-1 -: lfl_pkg::OP_BITS]);
  assign link      = q_data[LINK_BITS-1:0];
  assign head_null = (head_link[LINK_BITS-1 -: BATCH_BITS] == {BATCH_BITS{1'b1}});
  assign q_stall   = !((state == lfl_pkg::S_RUN) && (!result_valid || !result_stall));
  assign take      = q_valid && !q_stall;

  always_comb begin
    state_next       = state;
    head_link_next   = head_link;
    stall_count_next = stall_count;
    do_push          = 1'b0;
    res_got          = 1'b0;
    res_unst         = 1'b0;
    res_status       = lfl_pkg::STATUS_OK;
    res_popped       = '0;
    if (state == lfl_pkg::S_POP_WAIT) begin
      head_link_next = rdata;
      state_next     = lfl_pkg::S_RUN;
    end else if (take) begin
      unique case (code)
        lfl_pkg::OP_PUSH: begin
          do_push = 1'b1;
        end
        lfl_pkg::OP_POP, lfl_pkg::OP_POP_STALL: begin
          if (!head_null) begin
            res_got    = 1'b1;
            res_popped = head_link;
            state_next = lfl_pkg::S_POP_WAIT;
          end else if (code == lfl_pkg::OP_POP_STALL) begin
            if (stall_count == {STALL_BITS{1'b1}}) begin
              res_status = lfl_pkg::STATUS_OVERFLOW;
            end else begin
              stall_count_next = stall_count + {{(STALL_BITS-1){1'b0}}, 1'b1};
            end
          end
        end
        lfl_pkg::OP_PUSH_UNSTALL: begin
          do_push = 1'b1;
          if (stall_count != '0) begin
            stall_count_next = stall_count - {{(STALL_BITS-1){1'b0}}, 1'b1};
            res_unst         = 1'b1;
          end
        end
        lfl_pkg::OP_PUSH_HANDOFF: begin
          if (stall_count != '0) begin
            stall_count_next = stall_count - {{(STALL_BITS-1){1'b0}}, 1'b1};
            res_unst         = 1'b1;
          end else begin
            do_push = 1'b1;
          end
        end
        lfl_pkg::OP_NULL_PUSH: begin
          res_status = lfl_pkg::STATUS_NULL;
        end
        default: begin
        end
      endcase
      if (do_push) begin
        head_link_next = link;
      end
    end
  end

  // next-link memory: write on push, read at head every cycle
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[link] <= head_link;
    end
    rdata <= mem[head_link];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lfl_pkg::S_RUN;
      head_link    <= NULL_LINK;
      stall_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      state       <= state_next;
      head_link   <= head_link_next;
      stall_count <= stall_count_next;
      if (take) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      popped_link <= res_popped;
      got_entry   <= res_got;
      unstalled   <= res_unst;
      status      <= res_status;
      waiters     <= stall_count_next;
    end
  end

endmodule

### hw/rtl/linked_free_list_with_stall_count_top.sv
// linked free list with stall count: front classifier, operation queue, back executor
// an input transaction is registered in the operation queue, then its result in the back's result registers
// throughput: one transaction per cycle while the result side does not stall; a pop that
// returns an entry holds the next one in the pop-wait state for the synchronous read of the next-link memory
// reset: head link null, stall count zero, queue and result empty; memory not cleared
// depends on lfl_pkg, lfl_front, lfl_queue, lfl_back

module linked_free_list_with_stall_count_top #(
  parameter int BATCH_BITS = 4,
  parameter int INDEX_BITS = 6,
  parameter int STALL_BITS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [2:0]                       func,
  input  logic [BATCH_BITS+INDEX_BITS-1:0] entry_link,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [BATCH_BITS+INDEX_BITS-1:0] popped_link,
  output logic                             got_entry,
  output logic                             unstalled,
  output logic [1:0]                       status,
  output logic [STALL_BITS-1:0]            waiters
);

  localparam int Q_WIDTH = lfl_pkg::OP_BITS + BATCH_BITS + INDEX_BITS;

  logic               q_full;
  logic               q_wr;
  logic [Q_WIDTH-1:0] q_wr_data;
  logic               q_valid;
  logic               q_stall;
  logic [Q_WIDTH-1:0] q_data;

  lfl_front #(
    .BATCH_BITS (BATCH_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .func       (func),
    .entry_link (entry_link),
    .q_full     (q_full),
    .q_wr       (q_wr),
    .q_wr_data  (q_wr_data)
  );

  lfl_queue #(
    .WIDTH (Q_WIDTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_stall (q_stall),
    .rd_data  (q_data)
  );

  lfl_back #(
    .BATCH_BITS (BATCH_BITS),
    .INDEX_BITS (INDEX_BITS),
    .STALL_BITS (STALL_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_stall      (q_stall),
    .q_data       (q_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .popped_link  (popped_link),
    .got_entry    (got_entry),
    .unstalled    (unstalled),
    .status       (status),
    .waiters      (waiters)
  );

endmodule

### dv/linked_free_list_with_stall_count_top_test.sv
// self-checking test of the linked free list with stall count: directed, limit, pause,
// back-pressure and random transactions checked against an in-bench free list predictor
// depends on lfl_pkg and linked_free_list_with_stall_count_top

module linked_free_list_with_stall_count_top_test;

  localparam int BATCH_BITS = 4;
  localparam int INDEX_BITS = 6;
  localparam int STALL_BITS = 4;
  localparam int LINK_BITS = BATCH_BITS + INDEX_BITS;
  localparam logic [BATCH_BITS-1:0] NULL_BATCH = '1;
  localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FUNC_SPARE_LAST = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [LINK_BITS-1:0]  popped;
    logic                  got;
    logic                  unst;
    logic [1:0]            status;
    logic [STALL_BITS-1:0] waiters;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic [2:0]            func = lfl_pkg::FUNC_PUSH;
  logic [LINK_BITS-1:0]  entry_link = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [LINK_BITS-1:0]  popped_link;
  logic                  got_entry;
  logic                  unstalled;
  logic [1:0]            status;
  logic [STALL_BITS-1:0] waiters;

  // free list predictor state
  logic [LINK_BITS-1:0]  free_head = {NULL_BATCH, {INDEX_BITS{1'b0}}};
  logic [STALL_BITS-1:0] waiter_count = '0;
  logic [LINK_BITS-1:0]  succ_link [1 << LINK_BITS];

  outcome_t             expected_outcomes[$];
  logic [LINK_BITS-1:0] free_links[$];
  int                   err_count = 0;
  int                   quiet_cycles = 0;
  bit                   tx_idle = 1'b1;
  bit                   rx_idle = 1'b1;
  int                   hold_asked = 0;
  int                   hold_taken = 0;
  int                   hold_left = 0;

  linked_free_list_with_stall_count_top #(
    .BATCH_BITS(BATCH_BITS),
    .INDEX_BITS(INDEX_BITS),
    .STALL_BITS(STALL_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .func(func),
    .entry_link(entry_link),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .popped_link(popped_link),
    .got_entry(got_entry),
    .unstalled(unstalled),
    .status(status),
    .waiters(waiters)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit is_null(logic [LINK_BITS-1:0] l);
    return l[LINK_BITS-1:INDEX_BITS] == NULL_BATCH;
  endfunction

  function automatic void link_in(logic [LINK_BITS-1:0] l);
    succ_link[l] = free_head;
    free_head = l;
  endfunction

  function automatic outcome_t apply_free_list_op(logic [2:0] f, logic [LINK_BITS-1:0] l);
    outcome_t o;
    bit       pushes;
    o = '0;
    o.status = lfl_pkg::STATUS_OK;
    pushes = (f == lfl_pkg::FUNC_PUSH) || (f == lfl_pkg::FUNC_PUSH_UNSTALL) ||
             (f == lfl_pkg::FUNC_PUSH_HANDOFF);
    if (pushes && is_null(l)) begin
      o.status = lfl_pkg::STATUS_NULL;
    end else begin
      case (f)
        lfl_pkg::FUNC_PUSH: link_in(l);
        lfl_pkg::FUNC_POP, lfl_pkg::FUNC_POP_STALL: begin
          if (!is_null(free_head)) begin
            o.popped = free_head;
            o.got = 1'b1;
            free_head = succ_link[free_head];
          end else if (f == lfl_pkg::FUNC_POP_STALL) begin
            if (waiter_count == '1) o.status = lfl_pkg::STATUS_OVERFLOW;
            else waiter_count = waiter_count + 1'b1;
          end
        end
        lfl_pkg::FUNC_PUSH_UNSTALL: begin
          link_in(l);
          if (waiter_count != '0) begin
            waiter_count = waiter_count - 1'b1;
            o.unst = 1'b1;
          end
        end
        lfl_pkg::FUNC_PUSH_HANDOFF: begin
          if (waiter_count != '0) begin
            waiter_count = waiter_count - 1'b1;
            o.unst = 1'b1;
          end else begin
            link_in(l);
          end
        end
        default: ;
      endcase
    end
    o.waiters = waiter_count;
    return o;
  endfunction

  function automatic logic [LINK_BITS-1:0] rand_link();
    return {BATCH_BITS'($urandom_range(0, (1 << BATCH_BITS) - 2)), INDEX_BITS'($urandom)};
  endfunction

  task automatic send_item(input logic [2:0] f, input logic [LINK_BITS-1:0] l);
    outcome_t o;
    while (tx_idle && ($urandom_range(0, 99) < 30)) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    func <= f;
    entry_link <= l;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    o = apply_free_list_op(f, l);
    expected_outcomes.push_back(o);
    if (o.got) free_links.push_back(o.popped);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(lfl_pkg::FUNC_POP, '0);
    send_item(lfl_pkg::FUNC_PUSH, {NULL_BATCH, 6'd0});
    send_item(lfl_pkg::FUNC_PUSH_UNSTALL, '1);
    send_item(lfl_pkg::FUNC_PUSH_HANDOFF, {NULL_BATCH, 6'h2A});
    send_item(lfl_pkg::FUNC_PUSH, '0);
    send_item(lfl_pkg::FUNC_PUSH, 10'h3BF);
    send_item(lfl_pkg::FUNC_PUSH_UNSTALL, 10'h155);
    send_item(lfl_pkg::FUNC_PUSH_HANDOFF, 10'h2AA);
    repeat (4) send_item(lfl_pkg::FUNC_POP, '1);
    send_item(lfl_pkg::FUNC_POP, '0);
    repeat (2) send_item(lfl_pkg::FUNC_POP_STALL, '1);
    send_item(lfl_pkg::FUNC_PUSH_HANDOFF, 10'h000);
    send_item(lfl_pkg::FUNC_PUSH_UNSTALL, 10'h041);
    send_item(lfl_pkg::FUNC_POP_STALL, '0);
    send_item(lfl_pkg::FUNC_POP_STALL, '0);
    send_item(lfl_pkg::FUNC_PUSH_HANDOFF, {NULL_BATCH, 6'h3F});
    for (int c = FUNC_SPARE_FIRST; c <= FUNC_SPARE_LAST; c++) send_item(3'(c), rand_link());
    send_item(lfl_pkg::FUNC_PUSH_UNSTALL, 10'h100);
  endtask

  task automatic test_stall_limit();
    while (!is_null(free_head)) send_item(lfl_pkg::FUNC_POP, rand_link());
    repeat ((1 << STALL_BITS) + 1) send_item(lfl_pkg::FUNC_POP_STALL, rand_link());
    send_item(lfl_pkg::FUNC_PUSH_UNSTALL, rand_link());
    send_item(lfl_pkg::FUNC_POP_STALL, rand_link());
    send_item(lfl_pkg::FUNC_POP_STALL, rand_link());
    repeat ((1 << STALL_BITS) + 1) send_item(lfl_pkg::FUNC_PUSH_HANDOFF, rand_link());
  endtask

  task automatic test_sender_pause();
    repeat (12) begin
      send_item($urandom_range(0, 1) ? lfl_pkg::FUNC_PUSH : lfl_pkg::FUNC_POP, rand_link());
    end
    wait_drained();
    repeat (6) send_item(lfl_pkg::FUNC_POP, rand_link());
  endtask

  task automatic test_full_backpressure();
    tx_idle = 1'b0;
    hold_asked <= hold_asked + 1;
    for (int i = 0; i < 80; i++) begin
      send_item((i % 3 == 2) ? lfl_pkg::FUNC_POP : lfl_pkg::FUNC_PUSH, rand_link());
    end
    wait_drained();
    tx_idle = 1'b1;
  endtask

  task automatic test_random_traffic(input int n);
    int                   push_pct;
    logic [2:0]           f;
    logic [LINK_BITS-1:0] l;
    push_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) push_pct = $urandom_range(10, 90);
      if (i == 400) begin
        tx_idle = 1'b0;
        rx_idle <= 1'b0;
      end
      if (i == 550) begin
        tx_idle = 1'b1;
        rx_idle <= 1'b1;
      end
      if (i % 150 == 149) wait_drained();
      if ($urandom_range(0, 99) < 5) begin
        f = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
      end else if ($urandom_range(0, 99) < push_pct) begin
        case ($urandom_range(0, 2))
          0: f = lfl_pkg::FUNC_PUSH;
          1: f = lfl_pkg::FUNC_PUSH_UNSTALL;
          default: f = lfl_pkg::FUNC_PUSH_HANDOFF;
        endcase
      end else begin
        f = $urandom_range(0, 1) ? lfl_pkg::FUNC_POP_STALL : lfl_pkg::FUNC_POP;
      end
      if ($urandom_range(0, 99) < 8) l = {NULL_BATCH, INDEX_BITS'($urandom)};
      else if (free_links.size() != 0 && $urandom_range(0, 99) < 60) l = free_links.pop_front();
      else l = rand_link();
      send_item(f, l);
    end
  endtask

  // result side: random stall plus the long hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_taken) begin
      hold_taken <= hold_asked;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= rx_idle && ($urandom_range(0, 99) < 30);
    end
  end

  task automatic compare_field(input string name, input logic [LINK_BITS-1:0] exp_val,
                               input logic [LINK_BITS-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_outcomes.size() == 0) begin
        $error("result transaction with nothing outstanding");
        err_count++;
      end else begin
        want = expected_outcomes.pop_front();
        compare_field("popped_link", want.popped, popped_link);
        compare_field("got_entry", LINK_BITS'(want.got), LINK_BITS'(got_entry));
        compare_field("unstalled", LINK_BITS'(want.unst), LINK_BITS'(unstalled));
        compare_field("status", LINK_BITS'(want.status), LINK_BITS'(status));
        compare_field("waiters", LINK_BITS'(want.waiters), LINK_BITS'(waiters));
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_stall_limit();
    test_sender_pause();
    test_full_backpressure();
    test_random_traffic(790);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
